/* hdl/kps_pkg.sv */
// Shared types, widths and helpers for the nearest-point selector.
// No dependencies; every other file of the block uses this package.
package kps_pkg;

  localparam int COORD_W        = 24;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * DIFF_W;
  localparam int DIST_W         = 52;
  localparam int MT_W           = 6;
  localparam int RESULT_LIMIT   = 32;
  localparam int IDX_OUT_W      = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int MAX_POINTS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TARGETS = 2'd0,
    REG_ORIGIN_X    = 2'd1,
    REG_ORIGIN_Y    = 2'd2,
    REG_ORIGIN_Z    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic store;
    logic emit_init;
    logic scan_init;
    logic scan_step;
    logic emit_seq;
    logic emit_sel;
    logic clear;
  } kps_cmd_t;

  typedef struct packed {
    logic set_end;
    logic fits;
    logic none;
    logic scan_done;
    logic out_free;
    logic last_seq;
    logic last_sel;
  } kps_sts_t;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
  endfunction

endpackage

/* hdl/kps_if.sv */
// Valid/ready channel interfaces for points in and indices out.
// Depends on kps_pkg for field widths.
interface kps_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kps_pkg::COORD_W-1:0]   point_x;
  logic signed [kps_pkg::COORD_W-1:0]   point_y;
  logic signed [kps_pkg::COORD_W-1:0]   point_z;
  logic                                 set_end;

  modport source (output valid, point_x, point_y, point_z, set_end, input ready);
  modport sink   (input valid, point_x, point_y, point_z, set_end, output ready);
endinterface

interface kps_index_if;
  logic                               valid;
  logic                               ready;
  logic [kps_pkg::IDX_OUT_W-1:0]      target_index;
  logic                               list_end;
  logic                               dropped;

  modport source (output valid, target_index, list_end, dropped, input ready);
  modport sink   (input valid, target_index, list_end, dropped, output ready);
endinterface

/* hdl/kps_ctrl.sv */
// Controller state machine: sequences loading, squaring, storing and selection.
// Depends on kps_pkg for the command and status structs.
module kps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output kps_pkg::kps_cmd_t cmd,
  input  kps_pkg::kps_sts_t sts
);
  import kps_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQ0    = 8'b0000_0010,
    S_SQ1    = 8'b0000_0100,
    S_SQ2    = 8'b0000_1000,
    S_STORE  = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_SEQ    = 8'b0100_0000,
    S_SCAN   = 8'b1000_0000
  } state_t;

  typedef enum logic {
    PH_SCAN = 1'b0,
    PH_PICK = 1'b1
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_SCAN;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ0;
        end
      end
      S_SQ0: begin
        cmd.sq    = 1'b1;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.sq    = 1'b1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq    = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.set_end ? S_DECIDE : S_IDLE;
      end
      S_DECIDE: begin
        if (sts.fits) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_SEQ;
        end else if (sts.none) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.emit_init = 1'b1;
          cmd.scan_init = 1'b1;
          phase_nxt     = PH_SCAN;
          state_nxt     = S_SCAN;
        end
      end
      S_SEQ: begin
        if (sts.out_free) begin
          cmd.emit_seq = 1'b1;
          if (sts.last_seq) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (phase_r == PH_SCAN) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done) begin
            phase_nxt = PH_PICK;
          end
        end else if (sts.out_free) begin
          cmd.emit_sel = 1'b1;
          if (sts.last_sel) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            phase_nxt     = PH_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/kps_datapath.sv */
// Datapath: configuration registers, distance unit, distance memory,
// minimum search and the output register. Depends on kps_pkg.
module kps_datapath #(
  parameter int MAX_POINTS = kps_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [kps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [kps_pkg::COORD_W-1:0]        point_x,
  input  logic [kps_pkg::COORD_W-1:0]        point_y,
  input  logic [kps_pkg::COORD_W-1:0]        point_z,
  input  logic                               set_end,
  input  kps_pkg::kps_cmd_t                  cmd,
  output kps_pkg::kps_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kps_pkg::IDX_OUT_W-1:0]      target_index,
  output logic                               list_end,
  output logic                               dropped
);
  import kps_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > MT_W) ? CNT_W : MT_W;
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_POINTS);
  localparam logic [MT_W-1:0]  LIMIT_CAP = MT_W'(RESULT_LIMIT);

  logic [MT_W-1:0]    max_targets_r;
  logic [COORD_W-1:0] origin_x_r, origin_y_r, origin_z_r;

  logic [DIFF_W-1:0]  diff_r [3];
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  sq_w;
  logic [DIST_W-1:0]  acc_r;
  logic               end_r;

  logic [DIST_W-1:0]  mem [MAX_POINTS];
  logic [DIST_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  logic [CNT_W-1:0]   addr_r;

  logic [CNT_W-1:0]      cnt_r;
  logic                  ovf_r;
  logic [MAX_POINTS-1:0] mask_r;
  logic [CMP_W-1:0]      emit_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_r;
  logic [DIST_W-1:0]     best_d_r;

  logic                  out_valid_r;
  logic [IDX_OUT_W-1:0]  out_idx_r;
  logic                  out_last_r;
  logic                  out_drop_r;

  logic [MT_W-1:0]            lim_w;
  logic [CMP_W-1:0]           lim_x;
  logic [CMP_W-1:0]           cnt_x;
  logic [CMP_W-1:0]           emit_inc;
  logic                       full_w;
  logic [CMP_W+IDX_OUT_W-1:0] seq_wide;
  logic [IDX_W+IDX_OUT_W-1:0] sel_wide;
  logic                       better_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_targets_r <= MT_W'(1);
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      origin_z_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_TARGETS: max_targets_r <= cfg_data[MT_W-1:0];
        REG_ORIGIN_X:    origin_x_r    <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Z:    origin_z_r    <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign sq_w = diff_r[0] * diff_r[0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r[0] <= abs_diff(point_x, origin_x_r);
      diff_r[1] <= abs_diff(point_y, origin_y_r);
      diff_r[2] <= abs_diff(point_z, origin_z_r);
      prod_r    <= '0;
      acc_r     <= '0;
      end_r     <= set_end;
    end else if (cmd.sq) begin
      diff_r[0] <= diff_r[1];
      diff_r[1] <= diff_r[2];
      diff_r[2] <= '0;
      prod_r    <= sq_w;
      acc_r     <= acc_r + DIST_W'(prod_r);
    end
  end

  assign full_w = (cnt_r == CNT_FULL);

  always_ff @(posedge clk) begin
    if (cmd.store && !full_w) begin
      mem[cnt_r[IDX_W-1:0]] <= acc_r + DIST_W'(prod_r);
    end
    if (cmd.scan_step && (addr_r < cnt_r)) begin
      rd_data_r <= mem[addr_r[IDX_W-1:0]];
      rd_idx_r  <= addr_r[IDX_W-1:0];
    end
  end

  assign better_w = rd_vld_r && !mask_r[rd_idx_r] && (!found_r || (rd_data_r < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      addr_r   <= '0;
    end else if (cmd.scan_init) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      addr_r   <= '0;
    end else if (cmd.scan_step) begin
      rd_vld_r <= (addr_r < cnt_r);
      if (addr_r < cnt_r) begin
        addr_r <= addr_r + CNT_W'(1);
      end
      if (better_w) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && better_w) begin
      best_r   <= rd_idx_r;
      best_d_r <= rd_data_r;
    end
  end

  assign lim_w    = (max_targets_r > LIMIT_CAP) ? LIMIT_CAP : max_targets_r;
  assign lim_x    = CMP_W'(lim_w);
  assign cnt_x    = CMP_W'(cnt_r);
  assign emit_inc = emit_r + CMP_W'(1);
  assign seq_wide = {{IDX_OUT_W{1'b0}}, emit_r};
  assign sel_wide = {{IDX_OUT_W{1'b0}}, best_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      mask_r <= '0;
      emit_r <= '0;
    end else if (cmd.clear) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      mask_r <= '0;
      emit_r <= '0;
    end else begin
      if (cmd.store) begin
        if (full_w) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.emit_init) begin
        emit_r <= '0;
        mask_r <= '0;
      end else if (cmd.emit_seq || cmd.emit_sel) begin
        emit_r <= emit_inc;
      end
      if (cmd.emit_sel) begin
        mask_r[best_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_seq || cmd.emit_sel) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seq) begin
      out_idx_r  <= seq_wide[IDX_OUT_W-1:0];
      out_last_r <= (emit_inc == cnt_x);
      out_drop_r <= ovf_r;
    end else if (cmd.emit_sel) begin
      out_idx_r  <= sel_wide[IDX_OUT_W-1:0];
      out_last_r <= (emit_inc == lim_x);
      out_drop_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign target_index = out_idx_r;
  assign list_end     = out_last_r;
  assign dropped      = out_drop_r;

  always_comb begin
    sts           = '0;
    sts.set_end   = end_r;
    sts.fits      = (cnt_x <= lim_x);
    sts.none      = (lim_w == '0);
    sts.scan_done = (addr_r == cnt_r) && !rd_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
    sts.last_seq  = (emit_inc == cnt_x);
    sts.last_sel  = (emit_inc == lim_x);
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("point count exceeds store depth");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_seq || cmd.emit_sel) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sel |-> (found_r && (CNT_W'(best_r) < cnt_r)))
    else $error("selection pass ended without a stored candidate");

  a_pick_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sel |-> !mask_r[best_r])
    else $error("selected index was already emitted");

endmodule

/* hdl/k_nearest_point_select.sv */
// Top level of the nearest-point selector: controller plus datapath.
// Depends on kps_pkg, kps_if, kps_ctrl and kps_datapath.
//
//   Port        Role     Transfer carries
//   in_pt       sink     point_x, point_y, point_z, set_end
//   out_idx     source   target_index, list_end, dropped
//   cfg_*       write    cfg_index selects register, cfg_data holds the value
//
// Each point passes through accept, three squaring steps on the one shared multiplier,
// and the write into the distance memory.
// When every point fits the limit the indices leave at one per cycle unless the output stalls;
// otherwise each index costs one pass over the distance memory read port.
// Reset is synchronous and needs no clearing pass; the distance memory is never read unwritten.
// A stalled output holds the controller; a new set is accepted once the last index is loaded.
module k_nearest_point_select #(
  parameter int MAX_POINTS = kps_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data,
  kps_point_if.sink                      in_pt,
  kps_index_if.source                    out_idx
);
  import kps_pkg::*;

  kps_cmd_t cmd;
  kps_sts_t sts;

  kps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_ready (in_pt.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  kps_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_x      (in_pt.point_x),
    .point_y      (in_pt.point_y),
    .point_z      (in_pt.point_z),
    .set_end      (in_pt.set_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_idx.valid),
    .out_ready    (out_idx.ready),
    .target_index (out_idx.target_index),
    .list_end     (out_idx.list_end),
    .dropped      (out_idx.dropped)
  );

endmodule

/* tb/k_nearest_point_select_tb.sv */
// Self-checking testbench for the nearest-point selector k_nearest_point_select.
// It uses kps_pkg and the kps_point_if/kps_index_if channels. A directed table and
// random point sets are checked against a behavioural selector or a typed index.
module k_nearest_point_select_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int STORE_CAP = 32;
  localparam int SETTLE    = 40;
  localparam int DRAIN     = 64;
  localparam int QUIET_MAX = 2000;
  localparam int RAND_PTS  = 85;
  localparam int CALM_FROM = 65;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    cfg_reg_t                   reg_sel;
    logic [CFG_DATA_W-1:0]      value;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic                       last;
    bit                         typed;
    logic [IDX_OUT_W-1:0]       t_idx;
  } stim_row_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] idx;
    logic                 last;
    logic                 drop;
  } pick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kps_point_if pt_if ();
  kps_index_if idx_if ();

  k_nearest_point_select u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pt     (pt_if),
    .out_idx   (idx_if)
  );

  // Selector state mirrored on the testbench side.
  logic [MT_W-1:0]           sel_limit;
  logic signed [COORD_W-1:0] ref_org [3];
  logic [DIST_W-1:0]         dist_mem [STORE_CAP];
  int unsigned               n_stored;
  bit                        over_seen;

  pick_t     want_q [$];
  pick_t     fresh_picks [$];
  stim_row_t dir_tab [$];

  int n_err;
  int quiet;
  int stall_left;
  bit gaps_on;

  always #(CLK_HALF) clk = ~clk;

  function automatic void pick_nearest(input logic signed [COORD_W-1:0] px,
                                       input logic signed [COORD_W-1:0] py,
                                       input logic signed [COORD_W-1:0] pz,
                                       input logic last);
    logic signed [COORD_W-1:0] pt [3];
    logic [DIFF_W-1:0]         diff;
    logic [DIST_W-1:0]         acc;
    logic [DIST_W-1:0]         best_d;
    logic [STORE_CAP-1:0]      taken;
    int unsigned               lim;
    int unsigned               best;
    bit                        found;
    pick_t                     p;

    fresh_picks.delete();
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    acc = '0;
    for (int a = 0; a < 3; a++) begin
      diff = {pt[a][COORD_W-1], pt[a]} - {ref_org[a][COORD_W-1], ref_org[a]};
      if (diff[DIFF_W-1]) begin
        diff = -diff;
      end
      acc = acc + DIST_W'(diff) * DIST_W'(diff);
    end
    if (n_stored < STORE_CAP) begin
      dist_mem[n_stored] = acc;
      n_stored++;
    end else begin
      over_seen = 1'b1;
    end
    if (!last) begin
      return;
    end
    lim = (sel_limit > RESULT_LIMIT) ? RESULT_LIMIT : sel_limit;
    if (n_stored <= lim) begin
      for (int unsigned i = 0; i < n_stored; i++) begin
        p.idx  = IDX_OUT_W'(i);
        p.last = (i + 1 == n_stored);
        p.drop = over_seen;
        fresh_picks.push_back(p);
      end
    end else begin
      taken = '0;
      for (int unsigned k = 0; k < lim; k++) begin
        found  = 1'b0;
        best   = 0;
        best_d = '0;
        for (int unsigned i = 0; i < n_stored; i++) begin
          if (!taken[i] && (!found || dist_mem[i] < best_d)) begin
            found  = 1'b1;
            best   = i;
            best_d = dist_mem[i];
          end
        end
        taken[best] = 1'b1;
        p.idx  = IDX_OUT_W'(best);
        p.last = (k + 1 == lim);
        p.drop = over_seen;
        fresh_picks.push_back(p);
      end
    end
    n_stored  = 0;
    over_seen = 1'b0;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(
      input logic signed [COORD_W-1:0] centre);
    logic signed [COORD_W-1:0] c;

    case ($urandom_range(0, 9)) inside
      0: c = C_MAX;
      1: c = C_MIN;
      [2:5]: c = COORD_W'($urandom);
      default: c = centre + COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
    endcase
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_point(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic signed [COORD_W-1:0] pz,
                            input logic last,
                            input bit typed,
                            input logic [IDX_OUT_W-1:0] t_idx);
    pick_t p;

    cfg_wr_en <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.point_z <= pz;
    pt_if.set_end <= last;
    do @(posedge clk); while (!pt_if.ready);
    pick_nearest(px, py, pz, last);
    if (typed) begin
      p.idx  = t_idx;
      p.last = 1'b1;
      p.drop = 1'b0;
      want_q.push_back(p);
    end else begin
      foreach (fresh_picks[i]) want_q.push_back(fresh_picks[i]);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    pt_if.valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= v;
    case (sel)
      REG_MAX_TARGETS: sel_limit  = v[MT_W-1:0];
      REG_ORIGIN_X:    ref_org[0] = v;
      REG_ORIGIN_Y:    ref_org[1] = v;
      REG_ORIGIN_Z:    ref_org[2] = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      idx_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      idx_if.ready <= 1'b0;
    end else begin
      idx_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pick_t w;

    if (rst_n && idx_if.valid && idx_if.ready) begin
      if (want_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected index transfer: idx %0d end %0b drop %0b", $time,
                 idx_if.target_index, idx_if.list_end, idx_if.dropped);
      end else begin
        w = want_q.pop_front();
        if (idx_if.target_index !== w.idx || idx_if.list_end !== w.last ||
            idx_if.dropped !== w.drop) begin
          n_err++;
          $display("%0t: mismatch: expected idx %0d end %0b drop %0b, got idx %0d end %0b drop %0b",
                   $time, w.idx, w.last, w.drop,
                   idx_if.target_index, idx_if.list_end, idx_if.dropped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pt_if.valid && pt_if.ready) || (idx_if.valid && idx_if.ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          n_rand;
    int          len;
    int          pick;
    bit          first;
    logic [MT_W-1:0] mt;

    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    pt_if.set_end = 1'b0;
    idx_if.ready  = 1'b0;
    n_err         = 0;
    quiet         = 0;
    stall_left    = 0;
    gaps_on       = 1'b1;
    sel_limit     = MT_W'(1);
    ref_org[0]    = '0;
    ref_org[1]    = '0;
    ref_org[2]    = '0;
    n_stored      = 0;
    over_seen     = 1'b0;

    // A single point after reset, extremes, an equal-distance tie, a zero limit,
    // an origin moved part-way through a set and an oversized limit.
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd16, 24'sd0, 24'sd0, 1'b1, 1'b1, 5'd2});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd5, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd0, -24'sd5, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd0, 24'sd0, 24'sd5, 1'b1, 1'b1, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_MAX_TARGETS, 24'd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd1, 24'sd2, 24'sd3, 1'b1, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, -24'sd1, -24'sd1, -24'sd1, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd3, 24'sd3, 24'sd3, 1'b1, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_MAX_TARGETS, 24'd1, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd160, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, -24'sd80, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_ORIGIN_X, 24'd160, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd100, 24'sd0, 24'sd0, 1'b1, 1'b1, 5'd2});
    dir_tab.push_back('{ROW_WRITE, REG_MAX_TARGETS, 24'd2, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_ORIGIN_X, C_MIN, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_ORIGIN_Y, C_MAX, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_ORIGIN_Z, C_MIN, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, C_MAX, C_MIN, C_MAX, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, C_MIN, C_MAX, C_MIN, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_WRITE, REG_MAX_TARGETS, 24'hFFFFFF, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd1, 24'sd1, 24'sd1, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, 24'sd2, 24'sd2, 24'sd2, 1'b0, 1'b0, 5'd0});
    dir_tab.push_back('{ROW_POINT, REG_MAX_TARGETS, '0, -24'sd3, 24'sd0, 24'sd0, 1'b1, 1'b0, 5'd0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_WRITE) begin
          settle();
        end
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        send_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, dir_tab[i].last,
                   dir_tab[i].typed, dir_tab[i].t_idx);
      end
    end

    n_rand = 0;
    first  = 1'b1;
    while (n_rand < RAND_PTS) begin
      settle();
      case ($urandom_range(0, 7))
        0: mt = MT_W'(0);
        1: mt = MT_W'(1);
        2: mt = MT_W'(RESULT_LIMIT);
        3: mt = MT_W'($urandom_range(33, 63));
        default: mt = MT_W'($urandom_range(2, 12));
      endcase
      if (first) begin
        mt = MT_W'(4);
      end
      write_reg(REG_MAX_TARGETS, {(CFG_DATA_W - MT_W)'($urandom), mt});
      if (first || $urandom_range(0, 1) == 0) begin
        write_reg(REG_ORIGIN_X, rand_coord('0));
      end
      if (first || $urandom_range(0, 1) == 0) begin
        write_reg(REG_ORIGIN_Y, rand_coord('0));
      end
      if (first || $urandom_range(0, 1) == 0) begin
        write_reg(REG_ORIGIN_Z, rand_coord('0));
      end
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (first || pick == 0) begin
          len = $urandom_range(33, 35);
        end else if (pick < 4) begin
          len = $urandom_range(9, 32);
        end else begin
          len = $urandom_range(1, 8);
        end
        first = 1'b0;
        for (int j = 0; j < len; j++) begin
          if (j > 0 && j == len / 2 && $urandom_range(0, 5) == 0) begin
            settle();
            write_reg(cfg_reg_t'($urandom_range(1, 3)), rand_coord('0));
          end
          send_point(rand_coord(ref_org[0]), rand_coord(ref_org[1]),
                     rand_coord(ref_org[2]), j == len - 1, 1'b0, '0);
          n_rand++;
          gaps_on = (n_rand < CALM_FROM);
        end
      end
    end

    pt_if.valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
